### src/i2cmrt_pkg.sv
// ----------------------------------------------------------------------------
// i2cmrt_pkg
// types and constants shared by the register-transfer i2c master
// ----------------------------------------------------------------------------
package i2cmrt_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_TICKS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_POLL_LIMIT = 2'd2;

    localparam logic [6:0]  RST_TARGET_ADDRESS = 7'd64;
    localparam logic [15:0] RST_DELAY_TICKS    = 16'd5;
    localparam logic [7:0]  RST_ACK_POLL_LIMIT = 8'd250;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_RECOVER = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
    localparam logic [3:0] RECOVERY_PULSES = 4'd9;
    localparam logic [7:0] POLL_SATURATE   = 8'hFF;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST1    = 5'd1,
        PH_ST2    = 5'd2,
        PH_ST3    = 5'd3,
        PH_WB_SET = 5'd4,
        PH_WB_HI  = 5'd5,
        PH_WB_LO  = 5'd6,
        PH_AK1    = 5'd7,
        PH_AK2    = 5'd8,
        PH_AK3    = 5'd9,
        PH_RB_HI  = 5'd10,
        PH_RB_LO  = 5'd11,
        PH_MA1    = 5'd12,
        PH_MA2    = 5'd13,
        PH_MA3    = 5'd14,
        PH_MA4    = 5'd15,
        PH_MN1    = 5'd16,
        PH_MN2    = 5'd17,
        PH_MN3    = 5'd18,
        PH_RC_LO  = 5'd19,
        PH_RC_HI  = 5'd20,
        PH_SP1    = 5'd21,
        PH_SP2    = 5'd22,
        PH_SP3    = 5'd23
    } phase_t;

    typedef struct packed {
        logic [6:0]  target_address;
        logic [15:0] delay_ticks;
        logic [7:0]  ack_poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  reg_pointer;
        logic [15:0] write_value;
    } cmd_hold_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [1:0]  mode;
        logic [7:0]  reg_pointer;
        logic [15:0] write_value;
        logic        sda_sample;
    } in_item_t;

    typedef struct packed {
        logic        scl_release;
        logic        sda_release;
        logic        busy_res;
        logic        done_res;
        logic        failed;
        logic [15:0] read_value;
    } out_item_t;

endpackage

### src/i2cmrt_cfg.sv
// ----------------------------------------------------------------------------
// i2cmrt_cfg
// configuration register file: target address, step delay, ack poll limit
// ----------------------------------------------------------------------------
module i2cmrt_cfg
    import i2cmrt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_ADDRESS: cfg_next.target_address = cfg_data[6:0];
                REG_DELAY_TICKS:    cfg_next.delay_ticks    = cfg_data[15:0];
                REG_ACK_POLL_LIMIT: cfg_next.ack_poll_limit = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_address <= RST_TARGET_ADDRESS;
            cfg_reg.delay_ticks    <= RST_DELAY_TICKS;
            cfg_reg.ack_poll_limit <= RST_ACK_POLL_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/i2cmrt_seq.sv
// ----------------------------------------------------------------------------
// i2cmrt_seq
// bus sequencer: one tick of phase, counters and line levels per step
// ----------------------------------------------------------------------------
module i2cmrt_seq
    import i2cmrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    phase_t      phase_reg,  phase_next;
    logic [3:0]  bit_reg,    bit_next;
    logic [2:0]  byte_reg,   byte_next;
    logic [15:0] wait_reg,   wait_next;
    logic [7:0]  poll_reg,   poll_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [15:0] rhold_reg,  rhold_next;
    cmd_hold_t   cmd_reg,    cmd_next;
    logic        scl_reg,    scl_next;
    logic        sda_reg,    sda_next;
    logic        fail_reg,   fail_next;
    logic        done;
    logic [15:0] hold;
    logic [7:0]  wbyte;
    logic [7:0]  sh;
    logic [3:0]  bc;
    logic [7:0]  pc;
    logic [2:0]  bi;

    function automatic logic [7:0] byte_for(input logic [2:0] idx, input logic [6:0] addr,
                                           input cmd_hold_t c);
        logic [7:0] a8;
        a8 = {addr, 1'b0};
        case (idx)
            3'd0:    byte_for = a8;
            3'd1:    byte_for = c.reg_pointer;
            3'd2:    byte_for = (c.mode == MODE_READ) ? (a8 | 8'd1) : c.write_value[15:8];
            default: byte_for = c.write_value[7:0];
        endcase
    endfunction

    assign hold = (cfg.delay_ticks == 16'd0) ? 16'd1 : cfg.delay_ticks;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        wait_next  = wait_reg;
        poll_next  = poll_reg;
        shift_next = shift_reg;
        rhold_next = rhold_reg;
        cmd_next   = cmd_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        fail_next  = fail_reg;
        done       = 1'b0;
        wbyte      = 8'd0;
        sh         = 8'd0;
        bc         = 4'd0;
        pc         = 8'd0;
        bi         = 3'd0;
        if (step_en)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (item.cmd_valid && item.mode != MODE_NONE)
                begin
                    cmd_next   = {item.mode, item.reg_pointer, item.write_value};
                    fail_next  = 1'b0;
                    bit_next   = 4'd0;
                    byte_next  = 3'd0;
                    poll_next  = 8'd0;
                    shift_next = 8'd0;
                    wait_next  = 16'd0;
                    if (item.mode == MODE_RECOVER)
                    begin
                        phase_next = PH_RC_LO; scl_next = 1'b0; sda_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ST1; scl_next = 1'b1; sda_next = 1'b1;
                    end
                end
            end
            else if ({1'b0, wait_reg} + 17'd1 < {1'b0, hold})
            begin
                wait_next = wait_reg + 16'd1;
            end
            else
            begin
                wait_next = 16'd0;
                case (phase_reg)
                    PH_ST1:
                    begin
                        phase_next = PH_ST2; scl_next = 1'b1; sda_next = 1'b0;
                    end
                    PH_ST2:
                    begin
                        phase_next = PH_ST3; scl_next = 1'b0; sda_next = 1'b0;
                    end
                    PH_ST3:
                    begin
                        wbyte      = byte_for(byte_reg, cfg.target_address, cmd_reg);
                        shift_next = wbyte;
                        bit_next   = 4'd0;
                        phase_next = PH_WB_SET; scl_next = 1'b0; sda_next = wbyte[7];
                    end
                    PH_WB_SET:
                    begin
                        phase_next = PH_WB_HI; scl_next = 1'b1; sda_next = shift_reg[7];
                    end
                    PH_WB_HI:
                    begin
                        phase_next = PH_WB_LO; scl_next = 1'b0; sda_next = shift_reg[7];
                    end
                    PH_WB_LO:
                    begin
                        sh         = {shift_reg[6:0], 1'b0};
                        bc         = bit_reg + 4'd1;
                        shift_next = sh;
                        if (bc >= BITS_PER_BYTE)
                        begin
                            bit_next   = 4'd0;
                            poll_next  = 8'd0;
                            phase_next = PH_AK1; scl_next = 1'b0; sda_next = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bc;
                            phase_next = PH_WB_SET; scl_next = 1'b0; sda_next = sh[7];
                        end
                    end
                    PH_AK1:
                    begin
                        phase_next = PH_AK2; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    PH_AK2:
                    begin
                        if (!item.sda_sample)
                        begin
                            phase_next = PH_AK3; scl_next = 1'b0; sda_next = 1'b1;
                        end
                        else
                        begin
                            pc        = (poll_reg == POLL_SATURATE) ? poll_reg : poll_reg + 8'd1;
                            poll_next = pc;
                            if (pc > cfg.ack_poll_limit)
                            begin
                                fail_next  = 1'b1;
                                phase_next = PH_SP1; scl_next = scl_reg; sda_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_AK2; scl_next = 1'b1; sda_next = 1'b1;
                            end
                        end
                    end
                    PH_AK3:
                    begin
                        if (cmd_reg.mode == MODE_WRITE)
                        begin
                            if (byte_reg >= 3'd3)
                            begin
                                phase_next = PH_SP1; scl_next = scl_reg; sda_next = 1'b0;
                            end
                            else
                            begin
                                bi         = byte_reg + 3'd1;
                                byte_next  = bi;
                                wbyte      = byte_for(bi, cfg.target_address, cmd_reg);
                                shift_next = wbyte;
                                bit_next   = 4'd0;
                                phase_next = PH_WB_SET; scl_next = 1'b0; sda_next = wbyte[7];
                            end
                        end
                        else if (byte_reg == 3'd0)
                        begin
                            byte_next  = 3'd1;
                            wbyte      = byte_for(3'd1, cfg.target_address, cmd_reg);
                            shift_next = wbyte;
                            bit_next   = 4'd0;
                            phase_next = PH_WB_SET; scl_next = 1'b0; sda_next = wbyte[7];
                        end
                        else if (byte_reg == 3'd1)
                        begin
                            byte_next  = 3'd2;
                            phase_next = PH_ST1; scl_next = 1'b1; sda_next = 1'b1;
                        end
                        else
                        begin
                            byte_next  = 3'd3;
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RB_HI; scl_next = 1'b1; sda_next = 1'b1;
                        end
                    end
                    PH_RB_HI:
                    begin
                        shift_next = {shift_reg[6:0], item.sda_sample};
                        phase_next = PH_RB_LO; scl_next = 1'b0; sda_next = 1'b1;
                    end
                    PH_RB_LO:
                    begin
                        bc = bit_reg + 4'd1;
                        if (bc < BITS_PER_BYTE)
                        begin
                            bit_next   = bc;
                            phase_next = PH_RB_HI; scl_next = 1'b1; sda_next = 1'b1;
                        end
                        else
                        begin
                            bit_next = 4'd0;
                            if (byte_reg == 3'd3)
                            begin
                                cmd_next.write_value[7:0] = shift_reg;
                                phase_next = PH_MA1; scl_next = 1'b0; sda_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_MN1; scl_next = 1'b0; sda_next = 1'b1;
                            end
                        end
                    end
                    PH_MA1:
                    begin
                        phase_next = PH_MA2; scl_next = 1'b1; sda_next = 1'b0;
                    end
                    PH_MA2:
                    begin
                        phase_next = PH_MA3; scl_next = 1'b0; sda_next = 1'b0;
                    end
                    PH_MA3:
                    begin
                        phase_next = PH_MA4; scl_next = 1'b0; sda_next = 1'b1;
                    end
                    PH_MA4:
                    begin
                        byte_next  = 3'd4;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        phase_next = PH_RB_HI; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    PH_MN1:
                    begin
                        phase_next = PH_MN2; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    PH_MN2:
                    begin
                        phase_next = PH_MN3; scl_next = 1'b0; sda_next = 1'b1;
                    end
                    PH_MN3:
                    begin
                        phase_next = PH_SP1; scl_next = scl_reg; sda_next = 1'b0;
                    end
                    PH_RC_LO:
                    begin
                        phase_next = PH_RC_HI; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    PH_RC_HI:
                    begin
                        bc = bit_reg + 4'd1;
                        if (bc >= RECOVERY_PULSES)
                        begin
                            bit_next   = 4'd0;
                            phase_next = PH_SP1; scl_next = scl_reg; sda_next = 1'b0;
                        end
                        else
                        begin
                            bit_next   = bc;
                            phase_next = PH_RC_LO; scl_next = 1'b0; sda_next = 1'b1;
                        end
                    end
                    PH_SP1:
                    begin
                        phase_next = PH_SP2; scl_next = 1'b1; sda_next = 1'b0;
                    end
                    PH_SP2:
                    begin
                        phase_next = PH_SP3; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    default:
                    begin
                        if (cmd_reg.mode == MODE_READ && !fail_reg)
                        begin
                            rhold_next = {cmd_reg.write_value[7:0], shift_reg};
                        end
                        phase_next = PH_IDLE; scl_next = 1'b1; sda_next = 1'b1;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        result.scl_release = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.failed      = done & fail_next;
        result.read_value  = rhold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 4'd0;
            byte_reg  <= 3'd0;
            wait_reg  <= 16'd0;
            poll_reg  <= 8'd0;
            shift_reg <= 8'd0;
            rhold_reg <= 16'd0;
            cmd_reg   <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            fail_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            wait_reg  <= wait_next;
            poll_reg  <= poll_next;
            shift_reg <= shift_next;
            rhold_reg <= rhold_next;
            cmd_reg   <= cmd_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

### src/i2c_master_register_transfer.sv
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// tick-driven i2c master for 16-bit register write, read and bus recovery
// ----------------------------------------------------------------------------
// each beat on req carries one bus tick: an optional command plus the sampled
// sda level. each accepted req beat yields exactly one rsp beat with the scl
// and sda release levels, busy, done, failed and the last read value.
// a beat is taken when valid is high and stall is low on that channel.
// the rsp beat follows its req beat through the input register, then the result
// register; one beat per cycle is sustained while rsp is not stalled, set by the
// single pass of the sequencer step between those registers.
// when rsp is stalled the result register holds, the input register keeps
// its beat and req_stall rises only once the input register is occupied.
// configuration writes go through cfg_valid/cfg_ready (always ready); the user
// must make them only while no beat is in flight, which the block does not enforce.
// reset: both lines released, sequencer idle, registers at their defaults
// (address 64, delay 5, poll limit 250), read value zero.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer
    import i2cmrt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  in_item_t               req_data,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output out_item_t              rsp_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      rsp_valid_reg, rsp_valid_next;
    out_item_t rsp_data_reg;
    out_item_t step_result;
    cfg_t      cfg;
    logic      fire;
    logic      accept;

    i2cmrt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cmrt_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign fire      = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !fire;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        rsp_valid_next = fire || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req_data;
        end
        if (fire)
        begin
            rsp_data_reg <= step_result;
        end
    end

    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid)
        else $error("step result not presented");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg)
        else $error("req stalled with empty input register");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
        else $error("done reported while busy");

    a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.failed |-> rsp_data.done_res)
        else $error("failure flagged without done");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench for i2c_master_register_transfer
// every req beat is one bus tick and yields one rsp beat. a tick-level model
// of the sequencer predicts scl/sda levels, busy, done, failed and the read
// value for each accepted beat; every rsp beat is compared field by field.
// directed commands cover defaults, writes, reads, recovery, ack timeouts,
// poll saturation and delay extremes, then random commands run under several
// register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import i2cmrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {ACK_GIVEN, ACK_NEVER, ACK_RANDOM} ack_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    in_item_t               req_data = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    out_item_t              rsp_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // sequencer model state
    cfg_t       cfg;
    phase_t     seq_phase;
    logic [3:0] bit_cnt;
    logic [2:0] byte_cnt;
    logic [15:0] hold_cnt;
    logic [7:0] poll_cnt;
    logic [7:0] shift_reg;
    logic [15:0] read_word;
    cmd_hold_t  held_cmd;
    logic       scl_lvl;
    logic       sda_lvl;
    logic       timed_out;

    out_item_t  tick_status_q[$];
    ack_style_t ack_style = ACK_GIVEN;
    int         idle_odds = 0;
    int         stall_odds = 0;
    int         stall_left = 0;
    int         tick_count = 0;
    int         beat_count = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    i2c_master_register_transfer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void enter_step(phase_t ph, logic scl, logic sda);
        seq_phase = ph;
        scl_lvl = scl;
        sda_lvl = sda;
        hold_cnt = '0;
    endfunction

    function automatic void load_next_byte();
        logic [7:0] addr;
        addr = {cfg.target_address, 1'b0};
        case (byte_cnt)
            3'd0: shift_reg = addr;
            3'd1: shift_reg = held_cmd.reg_pointer;
            3'd2: shift_reg = (held_cmd.mode == MODE_READ) ? (addr | 8'h01)
                                                         : held_cmd.write_value[15:8];
            default: shift_reg = held_cmd.write_value[7:0];
        endcase
        bit_cnt = '0;
        enter_step(PH_WB_SET, 1'b0, shift_reg[7]);
    endfunction

    function automatic void begin_stop();
        enter_step(PH_SP1, scl_lvl, 1'b0);
    endfunction

    function automatic out_item_t step_sequencer(in_item_t beat);
        logic [16:0] span;
        logic        finished;
        logic        msb;
        out_item_t   status;
        span = (cfg.delay_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.delay_ticks};
        finished = 1'b0;
        msb = shift_reg[7];
        if (seq_phase == PH_IDLE)
        begin
            if (beat.cmd_valid && beat.mode != MODE_NONE)
            begin
                held_cmd.mode = beat.mode;
                held_cmd.reg_pointer = beat.reg_pointer;
                held_cmd.write_value = beat.write_value;
                timed_out = 1'b0;
                bit_cnt = '0;
                byte_cnt = '0;
                poll_cnt = '0;
                shift_reg = '0;
                if (beat.mode == MODE_RECOVER)
                    enter_step(PH_RC_LO, 1'b0, 1'b1);
                else
                    enter_step(PH_ST1, 1'b1, 1'b1);
            end
        end
        else if ({1'b0, hold_cnt} + 17'd1 < span)
        begin
            hold_cnt++;
        end
        else
        begin
            hold_cnt = '0;
            case (seq_phase)
                PH_ST1:    enter_step(PH_ST2, 1'b1, 1'b0);
                PH_ST2:    enter_step(PH_ST3, 1'b0, 1'b0);
                PH_ST3:    load_next_byte();
                PH_WB_SET: enter_step(PH_WB_HI, 1'b1, msb);
                PH_WB_HI:  enter_step(PH_WB_LO, 1'b0, msb);
                PH_WB_LO:
                begin
                    shift_reg = shift_reg << 1;
                    bit_cnt++;
                    if (bit_cnt >= BITS_PER_BYTE)
                    begin
                        bit_cnt = '0;
                        poll_cnt = '0;
                        enter_step(PH_AK1, 1'b0, 1'b1);
                    end
                    else
                    begin
                        enter_step(PH_WB_SET, 1'b0, shift_reg[7]);
                    end
                end
                PH_AK1:    enter_step(PH_AK2, 1'b1, 1'b1);
                PH_AK2:
                begin
                    if (beat.sda_sample == 1'b0)
                    begin
                        enter_step(PH_AK3, 1'b0, 1'b1);
                    end
                    else
                    begin
                        if (poll_cnt < POLL_SATURATE)
                            poll_cnt++;
                        if (poll_cnt > cfg.ack_poll_limit)
                        begin
                            timed_out = 1'b1;
                            begin_stop();
                        end
                        else
                        begin
                            enter_step(PH_AK2, 1'b1, 1'b1);
                        end
                    end
                end
                PH_AK3:
                begin
                    if (held_cmd.mode == MODE_WRITE)
                    begin
                        if (byte_cnt >= 3'd3)
                        begin
                            begin_stop();
                        end
                        else
                        begin
                            byte_cnt++;
                            load_next_byte();
                        end
                    end
                    else if (byte_cnt == 3'd0)
                    begin
                        byte_cnt = 3'd1;
                        load_next_byte();
                    end
                    else if (byte_cnt == 3'd1)
                    begin
                        // repeated start before the read address
                        byte_cnt = 3'd2;
                        enter_step(PH_ST1, 1'b1, 1'b1);
                    end
                    else
                    begin
                        byte_cnt = 3'd3;
                        bit_cnt = '0;
                        shift_reg = '0;
                        enter_step(PH_RB_HI, 1'b1, 1'b1);
                    end
                end
                PH_RB_HI:
                begin
                    shift_reg = {shift_reg[6:0], beat.sda_sample};
                    enter_step(PH_RB_LO, 1'b0, 1'b1);
                end
                PH_RB_LO:
                begin
                    bit_cnt++;
                    if (bit_cnt < BITS_PER_BYTE)
                    begin
                        enter_step(PH_RB_HI, 1'b1, 1'b1);
                    end
                    else
                    begin
                        bit_cnt = '0;
                        if (byte_cnt == 3'd3)
                        begin
                            held_cmd.write_value[7:0] = shift_reg;
                            enter_step(PH_MA1, 1'b0, 1'b0);
                        end
                        else
                        begin
                            enter_step(PH_MN1, 1'b0, 1'b1);
                        end
                    end
                end
                PH_MA1:    enter_step(PH_MA2, 1'b1, 1'b0);
                PH_MA2:    enter_step(PH_MA3, 1'b0, 1'b0);
                PH_MA3:    enter_step(PH_MA4, 1'b0, 1'b1);
                PH_MA4:
                begin
                    byte_cnt = 3'd4;
                    bit_cnt = '0;
                    shift_reg = '0;
                    enter_step(PH_RB_HI, 1'b1, 1'b1);
                end
                PH_MN1:    enter_step(PH_MN2, 1'b1, 1'b1);
                PH_MN2:    enter_step(PH_MN3, 1'b0, 1'b1);
                PH_MN3:    begin_stop();
                PH_RC_LO:  enter_step(PH_RC_HI, 1'b1, 1'b1);
                PH_RC_HI:
                begin
                    bit_cnt++;
                    if (bit_cnt >= RECOVERY_PULSES)
                    begin
                        bit_cnt = '0;
                        begin_stop();
                    end
                    else
                    begin
                        enter_step(PH_RC_LO, 1'b0, 1'b1);
                    end
                end
                PH_SP1:    enter_step(PH_SP2, 1'b1, 1'b0);
                PH_SP2:    enter_step(PH_SP3, 1'b1, 1'b1);
                default:
                begin
                    if (held_cmd.mode == MODE_READ && !timed_out)
                        read_word = {held_cmd.write_value[7:0], shift_reg};
                    enter_step(PH_IDLE, 1'b1, 1'b1);
                    finished = 1'b1;
                end
            endcase
        end
        status.scl_release = scl_lvl;
        status.sda_release = sda_lvl;
        status.busy_res = (seq_phase != PH_IDLE);
        status.done_res = finished;
        status.failed = finished & timed_out;
        status.read_value = read_word;
        return status;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 100)
            $display("mismatch at rsp beat %0d (%0t): %s", beat_count, $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (tick_status_q.size() == 0)
            begin
                report_mismatch("rsp beat with no tick pending");
            end
            else
            begin
                want = tick_status_q.pop_front();
                check_field("scl_release", 16'(rsp_data.scl_release), 16'(want.scl_release));
                check_field("sda_release", 16'(rsp_data.sda_release), 16'(want.sda_release));
                check_field("busy_res", 16'(rsp_data.busy_res), 16'(want.busy_res));
                check_field("done_res", 16'(rsp_data.done_res), 16'(want.done_res));
                check_field("failed", 16'(rsp_data.failed), 16'(want.failed));
                check_field("read_value", rsp_data.read_value, want.read_value);
            end
            beat_count++;
        end
    end

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            stall_left <= int'($urandom_range(0, 12));
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    task automatic send_tick(in_item_t beat);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= beat;
        do @(posedge clk); while (req_stall);
        tick_status_q.push_back(step_sequencer(beat));
        tick_count++;
    endtask

    function automatic in_item_t bus_tick();
        in_item_t beat;
        beat.cmd_valid = ($urandom_range(0, 3) == 0);
        beat.mode = 2'($urandom_range(0, 3));
        beat.reg_pointer = 8'($urandom);
        beat.write_value = 16'($urandom);
        beat.sda_sample = 1'($urandom_range(0, 1));
        if (seq_phase == PH_AK2)
        begin
            case (ack_style)
                ACK_GIVEN: beat.sda_sample = ($urandom_range(0, 3) == 0);
                ACK_NEVER: beat.sda_sample = 1'b1;
                default:   beat.sda_sample = 1'($urandom_range(0, 1));
            endcase
        end
        return beat;
    endfunction

    // idle ticks; a command on them uses the unused mode and is ignored
    task automatic quiet_ticks(int count);
        in_item_t beat;
        repeat (count)
        begin
            beat = bus_tick();
            if (beat.cmd_valid)
                beat.mode = MODE_NONE;
            send_tick(beat);
        end
    endtask

    task automatic run_command(logic [1:0] mode, logic [7:0] ptr, logic [15:0] wval,
                               ack_style_t style);
        in_item_t beat;
        beat.cmd_valid = 1'b1;
        beat.mode = mode;
        beat.reg_pointer = ptr;
        beat.write_value = wval;
        beat.sda_sample = 1'($urandom_range(0, 1));
        ack_style = style;
        send_tick(beat);
        while (seq_phase != PH_IDLE)
            send_tick(bus_tick());
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (tick_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TARGET_ADDRESS: cfg.target_address = value[6:0];
            REG_DELAY_TICKS:    cfg.delay_ticks = value;
            REG_ACK_POLL_LIMIT: cfg.ack_poll_limit = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [6:0] addr, logic [15:0] delay, logic [7:0] limit);
        wait_idle();
        push_reg(REG_TARGET_ADDRESS, {9'd0, addr});
        push_reg(REG_DELAY_TICKS, delay);
        push_reg(REG_ACK_POLL_LIMIT, {8'd0, limit});
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 10;
        endcase
    endfunction

    task automatic random_command();
        logic [1:0] mode;
        ack_style_t style;
        mode = 2'($urandom_range(0, 2));
        if (cfg.ack_poll_limit == POLL_SATURATE)
            style = ($urandom_range(0, 1) != 0) ? ACK_GIVEN : ACK_RANDOM;
        else
            case ($urandom_range(0, 9))
                6, 7: style = ACK_NEVER;
                8, 9: style = ACK_RANDOM;
                default: style = ACK_GIVEN;
            endcase
        if ($urandom_range(0, 5) == 0)
            quiet_ticks(int'($urandom_range(1, 6)));
        run_command(mode, 8'($urandom), 16'($urandom), style);
    endtask

    task automatic test_defaults();
        quiet_ticks(6);
        run_command(MODE_RECOVER, 8'hFF, 16'hFFFF, ACK_GIVEN);
        quiet_ticks(3);
    endtask

    task automatic test_register_write();
        apply_settings(7'd127, 16'd1, 8'd250);
        run_command(MODE_WRITE, 8'hA5, 16'h5AC3, ACK_RANDOM);
    endtask

    task automatic test_register_read();
        apply_settings(7'd0, 16'd1, 8'd250);
        run_command(MODE_READ, 8'hFF, 16'h0000, ACK_GIVEN);
    endtask

    task automatic test_bus_recovery();
        run_command(MODE_RECOVER, 8'h3C, 16'h1234, ACK_GIVEN);
        apply_settings(7'h2A, 16'd2, 8'd250);
        run_command(MODE_RECOVER, 8'hC3, 16'hEDCB, ACK_GIVEN);
    endtask

    task automatic test_ack_timeout();
        apply_settings(7'd64, 16'd1, 8'd0);
        run_command(MODE_WRITE, 8'h12, 16'h3456, ACK_NEVER);
        // a failed read leaves the last read value in place
        run_command(MODE_READ, 8'h34, 16'h0000, ACK_NEVER);
        apply_settings(7'd64, 16'd1, 8'd254);
        run_command(MODE_READ, 8'h56, 16'h0000, ACK_NEVER);
    endtask

    task automatic test_poll_saturate();
        apply_settings(7'd64, 16'd1, POLL_SATURATE);
        run_command(MODE_READ, 8'h9A, 16'h0000, ACK_RANDOM);
    endtask

    task automatic test_zero_delay();
        apply_settings(7'h55, 16'd0, 8'd3);
        run_command(MODE_RECOVER, 8'h77, 16'h0000, ACK_GIVEN);
    endtask

    task automatic test_slowest_delay();
        apply_settings(7'd64, 16'hFFFF, 8'd250);
        quiet_ticks(4);
    endtask

    task automatic test_random();
        int         commands;
        logic [7:0] limit;
        commands = 0;
        while (tick_count < 1100 || commands < 2)
        begin
            case ($urandom_range(0, 4))
                0: limit = 8'd0;
                1: limit = 8'd254;
                2: limit = POLL_SATURATE;
                default: limit = 8'($urandom_range(0, 254));
            endcase
            apply_settings(7'($urandom_range(0, 127)), 16'($urandom_range(0, 3)), limit);
            idle_odds = pick_odds();
            stall_odds = pick_odds();
            random_command();
            commands++;
        end
    endtask

    task automatic test_no_idling();
        idle_odds = 0;
        stall_odds = 0;
        apply_settings(7'($urandom_range(0, 127)), 16'd1, 8'($urandom_range(0, 254)));
        random_command();
    endtask

    initial
    begin
        cfg.target_address = RST_TARGET_ADDRESS;
        cfg.delay_ticks = RST_DELAY_TICKS;
        cfg.ack_poll_limit = RST_ACK_POLL_LIMIT;
        seq_phase = PH_IDLE;
        bit_cnt = '0;
        byte_cnt = '0;
        hold_cnt = '0;
        poll_cnt = '0;
        shift_reg = '0;
        read_word = '0;
        held_cmd = '0;
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
        timed_out = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_odds = 6;
        stall_odds = 8;
        test_defaults();
        test_register_write();
        test_register_read();
        test_bus_recovery();
        test_ack_timeout();
        test_poll_saturate();
        test_zero_delay();
        test_slowest_delay();
        test_random();
        test_no_idling();

        wait_idle();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
